@@ rtl/tjd_pkg.sv @@
`timescale 1ns / 1ps
package tjd_pkg;

   localparam int CACHE_PAIRS = 32;
   localparam int NUM_PE      = 8;
   localparam int ADDR_BITS   = 20;
   localparam int SLOT_BITS   = $clog2(CACHE_PAIRS);
   localparam int PE_BITS     = 3;
   localparam int CNT_BITS    = 20;
   localparam int LEN_BITS    = 6;
   localparam int LEVEL_BITS  = 4;

   localparam logic CSR_MAX_LEVEL_A = 1'b0;
   localparam logic CSR_MAX_LEVEL_B = 1'b1;

   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_PAIR    = 2'd2,
      MODE_COUNT   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_LAYER_COUNT = 3'd0,
      KIND_WRITE_ADDR  = 3'd1,
      KIND_READ_BURST  = 3'd2,
      KIND_DISPATCH    = 3'd3,
      KIND_FINISH      = 3'd4,
      KIND_TASK_COUNT  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_FILL     = 2'd1,
      PH_DISPATCH = 2'd2,
      PH_WAITCNT  = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_CNT, ST_WADDR, ST_ADV,
      ST_DISP, ST_DSEND, ST_FIN, ST_TASK, ST_DONE
   } state_type;

   typedef struct packed {
      mode_type              mode;
      logic [PE_BITS-1:0]    pe;
      logic [31:0]           pf;
      logic [31:0]           ps;
      logic [CNT_BITS-1:0]   cnt;
   } cmd_type;

   typedef struct packed {
      kind_type              kind;
      logic [31:0]           value;
      logic [LEN_BITS-1:0]   blen;
      logic [31:0]           pf;
      logic [31:0]           ps;
      logic [PE_BITS-1:0]    pe;
   } rsp_type;

endpackage

@@ rtl/tjd_front.sv @@
`timescale 1ns / 1ps
module tjd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_mode,
   input  logic [2:0]        req_pe_index,
   input  logic [31:0]       req_page_first,
   input  logic [31:0]       req_page_second,
   input  logic [19:0]       req_pair_count,
   output logic              cmd_valid,
   output tjd_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);
   import tjd_pkg::*;

   // Two-entry queue of classified transactions.
   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    req_cmd;

   always_comb begin
      req_cmd.mode = mode_type'(req_mode);
      req_cmd.pe   = req_pe_index;
      req_cmd.pf   = req_page_first;
      req_cmd.ps   = req_page_second;
      req_cmd.cnt  = req_pair_count;
      req_ready    = (count_ff != 2'd2);
      cmd_valid    = (count_ff != 2'd0);
      cmd          = slot_ff[rd_ptr_ff];
      push         = req_valid && req_ready;
      pop          = cmd_pop && cmd_valid;
      wr_ptr_in    = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

@@ rtl/tjd_back.sv @@
`timescale 1ns / 1ps
module tjd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  tjd_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [3:0]        csr_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tjd_pkg::rsp_type  rsp,
   output logic              rsp_last
);
   import tjd_pkg::*;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [ADDR_BITS-1:0]  total_ff, total_in;
   logic [ADDR_BITS-1:0]  start_ff, start_in;
   logic [ADDR_BITS-1:0]  next_ff, next_in;
   logic [ADDR_BITS-1:0]  base_ff, base_in;
   logic [LEN_BITS-1:0]   fill_ff, fill_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [NUM_PE-1:0]     busy_ff, busy_in;
   logic [31:0]           tot_ff [NUM_PE];
   cmd_type               cur_ff, cur_in;
   logic [PE_BITS-1:0]    pick_ff, pick_in;
   logic [PE_BITS-1:0]    tsk_ff, tsk_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_type               pend_ff, pend_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;
   logic                  out_last_ff, out_last_in;
   logic [3:0]            max_a_ff, max_b_ff;

   logic [63:0]           buf_mem [CACHE_PAIRS];
   logic [63:0]           buf_rd_ff;
   logic                  buf_we;
   logic [SLOT_BITS-1:0]  buf_waddr, buf_raddr;
   logic [63:0]           buf_wdata;

   logic                  emit, inc, clr_tot, out_free, can_emit, any_idle;
   rsp_type               emit_data;
   logic [LEVEL_BITS-1:0] depth;
   logic [ADDR_BITS-1:0]  rem, offset;
   logic [ADDR_BITS:0]    burst_end;
   logic [PE_BITS-1:0]    lowest_idle;

   always_comb begin
      // Depth is the larger tree.
      depth     = (max_a_ff > max_b_ff) ? max_a_ff : max_b_ff;
      rem       = total_ff - next_ff;
      offset    = next_ff - base_ff;
      burst_end = {1'b0, base_ff} + {{(ADDR_BITS+1-LEN_BITS){1'b0}}, len_ff};
      buf_raddr = offset[SLOT_BITS-1:0];
      any_idle    = 1'b0;
      lowest_idle = '0;
      for (int i = NUM_PE - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            any_idle    = 1'b1;
            lowest_idle = PE_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      level_in      = level_ff;
      total_in      = total_ff;
      start_in      = start_ff;
      next_in       = next_ff;
      base_in       = base_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      busy_in       = busy_ff;
      cur_in        = cur_ff;
      pick_in       = pick_ff;
      tsk_in        = tsk_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      cmd_pop       = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;
      inc           = 1'b0;
      clr_tot       = 1'b0;
      buf_we        = 1'b0;
      buf_waddr     = fill_ff[SLOT_BITS-1:0];
      buf_wdata     = {cur_ff.pf, cur_ff.ps};

      out_free = !out_valid_ff || rsp_ready;
      can_emit = !pend_valid_ff || out_free;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cur_in   = cmd;
               cmd_pop  = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (cur_ff.mode)
               MODE_START: begin
                  busy_in  = '0;
                  clr_tot  = 1'b1;
                  level_in = LEVEL_BITS'(1);
                  total_in = ADDR_BITS'(1);
                  start_in = '0;
                  next_in  = '0;
                  base_in  = '0;
                  fill_in  = '0;
                  len_in   = '0;
                  state_in = (depth == '0) ? ST_FIN : ST_CNT;
               end
               MODE_RELEASE: begin
                  if (int'(cur_ff.pe) < NUM_PE) begin
                     busy_in[cur_ff.pe] = 1'b0;
                     if (phase_ff == PH_DISPATCH) begin
                        state_in = ST_DISP;
                     end
                  end
               end
               MODE_PAIR: begin
                  if (phase_ff == PH_FILL && fill_ff < len_ff) begin
                     buf_we  = 1'b1;
                     fill_in = fill_ff + LEN_BITS'(1);
                     if (fill_in >= len_ff) begin
                        state_in = ST_DISP;
                     end
                  end
               end
               MODE_COUNT: begin
                  if (phase_ff == PH_WAITCNT) begin
                     start_in = start_ff + total_ff;
                     total_in = cur_ff.cnt;
                     level_in = level_ff + LEVEL_BITS'(1);
                     state_in = ST_CNT;
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_CNT: begin
            if (can_emit) begin
               emit            = 1'b1;
               emit_data.kind  = KIND_LAYER_COUNT;
               emit_data.value = 32'(total_ff);
               state_in        = ST_WADDR;
            end
         end
         ST_WADDR: begin
            if (can_emit) begin
               emit            = 1'b1;
               emit_data.kind  = KIND_WRITE_ADDR;
               emit_data.value = 32'(ADDR_BITS'(start_ff + total_ff));
               next_in         = '0;
               state_in        = ST_ADV;
            end
         end
         ST_ADV: begin
            if (next_ff < total_ff) begin
               if (can_emit) begin
                  emit            = 1'b1;
                  emit_data.kind  = KIND_READ_BURST;
                  emit_data.value = 32'(ADDR_BITS'(start_ff + next_ff));
                  emit_data.blen  = (rem < ADDR_BITS'(CACHE_PAIRS)) ?
                                    rem[LEN_BITS-1:0] : LEN_BITS'(CACHE_PAIRS);
                  base_in         = next_ff;
                  len_in          = emit_data.blen;
                  fill_in         = '0;
                  phase_in        = PH_FILL;
                  state_in        = ST_DONE;
               end
            end else begin
               fill_in = '0;
               len_in  = '0;
               base_in = '0;
               if (level_ff < depth) begin
                  phase_in = PH_WAITCNT;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DISP: begin
            if ({1'b0, next_ff} < burst_end) begin
               if (any_idle) begin
                  pick_in  = lowest_idle;
                  state_in = ST_DSEND;
               end else begin
                  phase_in = PH_DISPATCH;
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_DSEND: begin
            if (can_emit) begin
               emit              = 1'b1;
               emit_data.kind    = KIND_DISPATCH;
               emit_data.pf      = buf_rd_ff[63:32];
               emit_data.ps      = buf_rd_ff[31:0];
               emit_data.pe      = pick_ff;
               busy_in[pick_ff]  = 1'b1;
               inc               = 1'b1;
               next_in           = next_ff + ADDR_BITS'(1);
               state_in          = ST_DISP;
            end
         end
         ST_FIN: begin
            if (can_emit) begin
               emit            = 1'b1;
               emit_data.kind  = KIND_FINISH;
               emit_data.value = 32'd1;
               tsk_in          = '0;
               state_in        = ST_TASK;
            end
         end
         ST_TASK: begin
            if (can_emit) begin
               emit            = 1'b1;
               emit_data.kind  = KIND_TASK_COUNT;
               emit_data.value = tot_ff[tsk_ff];
               emit_data.pe    = tsk_ff;
               if (int'(tsk_ff) == NUM_PE - 1) begin
                  phase_in = PH_IDLE;
                  state_in = ST_DONE;
               end else begin
                  tsk_in = tsk_ff + PE_BITS'(1);
               end
            end
         end
         ST_DONE: begin
            // The held result is the final one of this transaction.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A new result pushes the held one out as not final.
      if (emit) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_IDLE;
         level_ff      <= '0;
         total_ff      <= '0;
         start_ff      <= '0;
         next_ff       <= '0;
         base_ff       <= '0;
         fill_ff       <= '0;
         len_ff        <= '0;
         busy_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         max_a_ff      <= '0;
         max_b_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         level_ff      <= level_in;
         total_ff      <= total_in;
         start_ff      <= start_in;
         next_ff       <= next_in;
         base_ff       <= base_in;
         fill_ff       <= fill_in;
         len_ff        <= len_in;
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_write_enable && csr_index == CSR_MAX_LEVEL_A) begin
            max_a_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CSR_MAX_LEVEL_B) begin
            max_b_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pick_ff     <= pick_in;
      tsk_ff      <= tsk_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_PE; i++) begin
         if (reset || clr_tot) begin
            tot_ff[i] <= '0;
         end else if (inc && int'(pick_ff) == i) begin
            tot_ff[i] <= tot_ff[i] + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_waddr] <= buf_wdata;
      end
      buf_rd_ff <= buf_mem[buf_raddr];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign rsp_last  = out_last_ff;

endmodule

@@ rtl/tree_join_task_dispatcher_top.sv @@
`timescale 1ns / 1ps
// Tree-join task dispatcher. Each request transaction is queued by a small
// front stage (two entries) and then executed by a back-end sequencer that
// produces the resulting response transactions through an output register
// and takes a new request only when done; the final response of a request
// carries rsp_last. A request moves from the queue to a command register
// before it executes; each pair is dispatched in a select and a send state
// as the pair buffer is a memory with a registered read port. The sequencer
// holds one response back to learn whether it is final, so each response
// passes a holding register before the output register. Configuration writes
// (index 0 and 1, the two tree depths) are taken at any time but should
// only be made while idle.
module tree_join_task_dispatcher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_pe_index,
   input  logic [31:0] req_page_first,
   input  logic [31:0] req_page_second,
   input  logic [19:0] req_pair_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_value,
   output logic [5:0]  rsp_burst_len,
   output logic [31:0] rsp_out_page_first,
   output logic [31:0] rsp_out_page_second,
   output logic [2:0]  rsp_target_pe,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data
);
   import tjd_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   // The front stage accepts and classifies request transactions.
   tjd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_pe_index    (req_pe_index),
      .req_page_first  (req_page_first),
      .req_page_second (req_page_second),
      .req_pair_count  (req_pair_count),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // The back end walks the levels, buffers bursts and assigns pairs.
   tjd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp),
      .rsp_last         (rsp_last)
   );

   assign rsp_kind            = rsp.kind;
   assign rsp_value           = rsp.value;
   assign rsp_burst_len       = rsp.blen;
   assign rsp_out_page_first  = rsp.pf;
   assign rsp_out_page_second = rsp.ps;
   assign rsp_target_pe       = rsp.pe;

endmodule
